// File: rtl/wfa_pkg.sv
package wfa_pkg;

    localparam int TAPS_MAX    = 5;
    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 11;
    // effective weight can collect all five weights onto the centre frame
    localparam int EFF_W       = 14;
    localparam int FLAG_W      = 5;
    localparam int DIV_W       = 16;
    localparam int SBITS_W     = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = SAMPLE_W + 1 + EFF_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int DIV_STEPS   = SAMPLE_W;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_0    = 3'd0,
        REG_WEIGHT_1    = 3'd1,
        REG_WEIGHT_2    = 3'd2,
        REG_WEIGHT_3    = 3'd3,
        REG_WEIGHT_4    = 3'd4,
        REG_DIVISOR     = 3'd5,
        REG_SAMPLE_BITS = 3'd6,
        REG_CUT_GUARD   = 3'd7
    } wfa_reg_t;

    typedef struct packed {
        logic [TAPS_MAX-1:0][WEIGHT_W-1:0] weight;
        logic [DIV_W-1:0]                  divisor;
        logic [SAMPLE_W-1:0]               max_val;
        logic                              cut_guard;
    } wfa_cfg_t;

    typedef struct packed {
        logic [TAPS_MAX-1:0][SAMPLE_W-1:0] sample;
        logic [TAPS_MAX-1:0][EFF_W-1:0]    weight;
    } wfa_work_t;

endpackage

// File: rtl/wfa_if.sv
interface wfa_in_if;
    import wfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [FLAG_W-1:0]   prev_cut_flags;
    logic [FLAG_W-1:0]   next_cut_flags;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
               prev_cut_flags, next_cut_flags,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
               prev_cut_flags, next_cut_flags,
        output ready
    );
endinterface

interface wfa_out_if;
    import wfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] result_sample;

    modport source (
        output valid, result_sample,
        input  ready
    );
    modport sink (
        input  valid, result_sample,
        output ready
    );
endinterface

// File: rtl/wfa_front.sv
module wfa_front #(
    parameter int TAPS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wfa_pkg::wfa_cfg_t  cfg,
    wfa_in_if.sink             frames,
    input  logic               q_full,
    output logic               q_push,
    output wfa_pkg::wfa_work_t work
);
    import wfa_pkg::*;

    localparam int CENTRE = TAPS / 2;

    logic                        valid_reg;
    logic                        valid_next;
    wfa_work_t                   work_reg;
    wfa_work_t                   work_next;
    logic                        accept;
    logic [FLAG_W-1:0]           pflags;
    logic [FLAG_W-1:0]           nflags;
    logic [2:0]                  first_keep;
    logic [2:0]                  last_keep;
    logic signed [EFF_W-1:0]     w_eff [TAPS_MAX];
    logic signed [EFF_W-1:0]     moved;

    assign frames.ready = !valid_reg || !q_full;
    assign accept       = frames.valid && frames.ready;
    assign q_push       = valid_reg && !q_full;
    assign work         = work_reg;
    assign pflags       = frames.prev_cut_flags;
    assign nflags       = frames.next_cut_flags;

    // nearest cut on each side of the centre frame
    always_comb
    begin
        first_keep = 3'd0;
        last_keep  = 3'(TAPS);
        for (int i = 1; i <= CENTRE; i++)
        begin
            if (pflags[i])
            begin
                first_keep = 3'(i);
            end
        end
        for (int i = TAPS - 2; i >= CENTRE; i--)
        begin
            if (nflags[i])
            begin
                last_keep = 3'(i);
            end
        end
    end

    // fold weights of frames beyond the cuts onto the centre when the cut guard is on
    always_comb
    begin
        moved = '0;
        for (int i = 0; i < TAPS_MAX; i++)
        begin
            if (i < TAPS)
            begin
                w_eff[i] = EFF_W'($signed(cfg.weight[i]));
            end
            else
            begin
                w_eff[i] = '0;
            end
            if (cfg.cut_guard && (i < TAPS)
                && ((3'(i) < first_keep) || (3'(i) > last_keep)))
            begin
                moved    = moved + w_eff[i];
                w_eff[i] = '0;
            end
        end
        w_eff[CENTRE] = w_eff[CENTRE] + moved;
    end

    always_comb
    begin
        work_next.sample[0] = frames.sample_0;
        work_next.sample[1] = frames.sample_1;
        work_next.sample[2] = frames.sample_2;
        work_next.sample[3] = frames.sample_3;
        work_next.sample[4] = frames.sample_4;
        for (int i = 0; i < TAPS_MAX; i++)
        begin
            work_next.weight[i] = w_eff[i];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg <= work_next;
        end
    end

endmodule

// File: rtl/wfa_queue.sv
module wfa_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  wfa_pkg::wfa_work_t push_data,
    input  logic               pop,
    output wfa_pkg::wfa_work_t head,
    output logic               full,
    output logic               empty
);
    import wfa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    wfa_work_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/wfa_back.sv
module wfa_back #(
    parameter int TAPS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wfa_pkg::wfa_cfg_t  cfg,
    input  wfa_pkg::wfa_work_t head,
    input  logic               q_empty,
    output logic               q_pop,
    wfa_out_if.source          result
);
    import wfa_pkg::*;

    logic                        adv;

    logic                        v1_reg;
    logic signed [PROD_W-1:0]    prod_reg  [TAPS_MAX];
    logic signed [PROD_W-1:0]    prod_next [TAPS_MAX];

    logic                        v2_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;

    logic [ACC_W-2:0]            pos;
    logic [ACC_W-1:0]            num;
    logic                        sat0;

    logic                        dv_reg    [DIV_STEPS+1];
    logic                        sat_reg   [DIV_STEPS+1];
    logic [DIV_W-1:0]            rem_reg   [DIV_STEPS+1];
    logic [DIV_W-1:0]            rem_next  [DIV_STEPS+1];
    logic [SAMPLE_W-1:0]         sh_reg    [DIV_STEPS+1];
    logic [SAMPLE_W-1:0]         sh_next   [DIV_STEPS+1];

    logic                        out_valid_reg;
    logic [SAMPLE_W-1:0]         out_reg;
    logic [SAMPLE_W-1:0]         out_next;

    // whole back pipeline moves together unless the output is held
    assign adv   = !out_valid_reg || result.ready;
    assign q_pop = adv && !q_empty;

    always_comb
    begin
        for (int i = 0; i < TAPS_MAX; i++)
        begin
            if (i < TAPS)
            begin
                prod_next[i] = $signed({1'b0, head.sample[i]}) * $signed(head.weight[i]);
            end
            else
            begin
                prod_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        acc_next = '0;
        for (int i = 0; i < TAPS_MAX; i++)
        begin
            acc_next = acc_next + ACC_W'(prod_reg[i]);
        end
    end

    // clamp at zero, bias for round-up, flag quotients past 16 bits
    always_comb
    begin
        pos  = acc_reg[ACC_W-1] ? '0 : acc_reg[ACC_W-2:0];
        num  = ACC_W'(pos) + ACC_W'(cfg.divisor) - ACC_W'(1);
        sat0 = (num >= ACC_W'({cfg.divisor, {SAMPLE_W{1'b0}}}));
    end

    // one quotient bit per stage, restoring
    always_comb
    begin
        logic [DIV_W:0] trial;
        logic           ge;
        rem_next[0] = DIV_W'(num >> SAMPLE_W);
        sh_next[0]  = num[SAMPLE_W-1:0];
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            trial = {rem_reg[k-1], sh_reg[k-1][SAMPLE_W-1]};
            ge    = (trial >= {1'b0, cfg.divisor});
            if (ge)
            begin
                rem_next[k] = DIV_W'(trial - {1'b0, cfg.divisor});
            end
            else
            begin
                rem_next[k] = trial[DIV_W-1:0];
            end
            sh_next[k] = {sh_reg[k-1][SAMPLE_W-2:0], ge};
        end
    end

    always_comb
    begin
        if (sat_reg[DIV_STEPS] || (sh_reg[DIV_STEPS] > cfg.max_val))
        begin
            out_next = cfg.max_val;
        end
        else
        begin
            out_next = sh_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg        <= !q_empty;
            v2_reg        <= v1_reg;
            dv_reg[0]     <= v2_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            out_valid_reg <= dv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < TAPS_MAX; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            acc_reg    <= acc_next;
            sat_reg[0] <= sat0;
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                sh_reg[k]  <= sh_next[k];
            end
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                sat_reg[k] <= sat_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.result_sample = out_reg;

endmodule

// File: rtl/weighted_frame_average_top.sv
// path: front register, queue, product, sum, quotient stages, output register
// throughput: one item per cycle unless the output is held; the multiply
// stage and the 16-stage quotient pipeline take a new item each cycle they
// advance, a two-entry queue between front and back lets either side stall alone
// reset: weights 0,0,1,0,0, divisor 1, sample bits 8, cut guard off; all
// pipeline and queue valid state cleared
module weighted_frame_average_top #(
    parameter int TAPS = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wfa_pkg::CFG_DATA_W-1:0] cfg_data,
    wfa_in_if.sink                         frames,
    wfa_out_if.source                      result
);
    import wfa_pkg::*;

    // configuration registers
    logic [TAPS_MAX-1:0][WEIGHT_W-1:0] weight_reg;
    logic [TAPS_MAX-1:0][WEIGHT_W-1:0] weight_next;
    logic [DIV_W-1:0]                  divisor_reg;
    logic [DIV_W-1:0]                  divisor_next;
    logic [SBITS_W-1:0]                sample_bits_reg;
    logic [SBITS_W-1:0]                sample_bits_next;
    logic                              cut_guard_reg;
    logic                              cut_guard_next;

    // derived settings seen by both halves
    wfa_cfg_t                          cfg;
    logic [SBITS_W-1:0]                bits_eff;
    logic [SAMPLE_W:0]                 max_wide;

    // queue hookup
    logic                              q_push;
    logic                              q_full;
    logic                              q_pop;
    logic                              q_empty;
    wfa_work_t                         front_work;
    wfa_work_t                         q_head;

    // register writes, decoded by index
    always_comb
    begin
        weight_next      = weight_reg;
        divisor_next     = divisor_reg;
        sample_bits_next = sample_bits_reg;
        cut_guard_next   = cut_guard_reg;
        if (cfg_wr_en)
        begin
            case (wfa_reg_t'(cfg_index))
                REG_WEIGHT_0:    weight_next[0]   = cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_1:    weight_next[1]   = cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_2:    weight_next[2]   = cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_3:    weight_next[3]   = cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_4:    weight_next[4]   = cfg_data[WEIGHT_W-1:0];
                REG_DIVISOR:     divisor_next     = cfg_data[DIV_W-1:0];
                REG_SAMPLE_BITS: sample_bits_next = cfg_data[SBITS_W-1:0];
                REG_CUT_GUARD:   cut_guard_next   = cfg_data[0];
                default:         cut_guard_next   = cut_guard_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // centre weight one, all others zero
            weight_reg      <= {WEIGHT_W'(0), WEIGHT_W'(0), WEIGHT_W'(1),
                                WEIGHT_W'(0), WEIGHT_W'(0)};
            divisor_reg     <= DIV_W'(1);
            sample_bits_reg <= SBITS_W'(8);
            cut_guard_reg   <= 1'b0;
        end
        else
        begin
            weight_reg      <= weight_next;
            divisor_reg     <= divisor_next;
            sample_bits_reg <= sample_bits_next;
            cut_guard_reg   <= cut_guard_next;
        end
    end

    // zero divisor acts as one; sample width caps at 16 bits
    always_comb
    begin
        bits_eff      = (sample_bits_reg > SBITS_W'(SAMPLE_W)) ? SBITS_W'(SAMPLE_W)
                                                               : sample_bits_reg;
        max_wide      = ((SAMPLE_W + 1)'(1) << bits_eff) - (SAMPLE_W + 1)'(1);
        cfg.weight    = weight_reg;
        cfg.divisor   = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;
        cfg.max_val   = max_wide[SAMPLE_W-1:0];
        cfg.cut_guard = cut_guard_reg;
    end

    // front: accept, locate scene cuts, fold weights
    wfa_front #(
        .TAPS (TAPS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .frames (frames),
        .q_full (q_full),
        .q_push (q_push),
        .work   (front_work)
    );

    // short decoupling queue
    wfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_work),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: multiply, sum, clamp, divide with round-up, saturate
    wfa_back #(
        .TAPS (TAPS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result)
    );

`ifndef SYNTHESIS
    // a held result must freeze the back pipeline
    a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !q_pop)
        else $error("queue popped while result held");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // a pushed item makes the queue non-empty on the next edge
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> !q_empty)
        else $error("pushed item lost");
`endif

endmodule
